// ===== sv/rba_pkg.sv =====
package rba_pkg;

	localparam int unsigned UNIT_SHIFT = 4;
	localparam int unsigned UNIT_BYTES = 16;
	localparam logic [3:0] UNIT_MASK = 4'(UNIT_BYTES - 1);

	typedef enum logic {
		OP_ASSIGN = 1'b0,
		OP_ADD    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_FIT  = 2'd1,
		STATUS_NO_SLOT = 2'd2
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [11:0] request_size;
		logic        is_temp;
		logic [15:0] region_segment;
		logic [15:0] region_offset;
		logic [15:0] region_bytes;
	} in_item_t;

	typedef struct packed {
		logic [15:0] grant_segment;
		logic [15:0] total_left;
		status_t     status;
	} out_item_t;

	// One region slot: next free unit (0 = empty slot) and units left.
	typedef struct packed {
		logic [15:0] next;
		logic [15:0] left;
	} entry_t;

endpackage

// ===== sv/rba_in_if.sv =====
interface rba_in_if;
	logic               valid;
	logic               ready;
	rba_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rba_out_if.sv =====
interface rba_out_if;
	logic               valid;
	logic               ready;
	rba_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rba_ram.sv =====
module rba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 7
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/region_bump_allocator.sv =====
// First-fit bump allocator over REGIONS memory regions with one checkpoint.
// Each beat on item is either an add (fill the first empty slot with a region
// aligned up to a 16-byte unit) or an assign (carve request_size units off the
// first region that fits). Every item yields exactly one beat on result with
// the granted segment (0 when none), the total free units and a status code.
// The first successful temporary assign checkpoints all regions; the next
// non-temporary assign rolls back to that checkpoint before it is served.
// Region state and checkpoint live in two RAMs with a registered read, so work
// goes one slot per cycle: the item is accepted, the first read is issued,
// then slots are read in order up to the hit, or through every slot on a miss;
// an assign hit adds a bump step, and the result register is then loaded. A
// rollback copy or a checkpoint copy adds a pass over every slot. An item is
// held in S_RESP only while the previous result beat still waits downstream.
// One item is in flight at a time; a new item is taken while the previous
// result beat still waits downstream.
// No clearing pass: a valid bit per live slot makes a slot never written since
// reset read as empty, and the checkpoint is always copied whole before use.
module region_bump_allocator #(
	parameter int unsigned REGIONS = 7
) (
	input  logic     clk,
	input  logic     arst_n,
	rba_in_if.sink   item,
	rba_out_if.source result
);

	localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int unsigned CNT_W = $clog2(REGIONS + 1);
	localparam int unsigned ENT_W = $bits(rba_pkg::entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESTORE,
		S_SCAN,
		S_TAKE,
		S_BUMP,
		S_RESP
	} state_t;

	state_t              state_q;
	rba_pkg::in_item_t   item_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [IDX_W-1:0]    hit_idx_q;
	rba_pkg::entry_t     hit_q;
	logic [15:0]         total_free_q;
	logic [15:0]         saved_total_q;
	logic                temp_active_q;
	logic                written_q [REGIONS];
	rba_pkg::out_item_t  res_q;
	logic                out_vld_q;
	rba_pkg::out_item_t  out_q;

	// RAM ports
	logic                live_we, snap_we;
	logic [IDX_W-1:0]    live_waddr, snap_waddr, rd_addr;
	logic [ENT_W-1:0]    live_wdata, snap_wdata, live_rdata_raw, snap_rdata_raw;
	rba_pkg::entry_t     live_rdata, snap_rdata;

	logic                issue_done;
	logic                slot_hit;
	logic                out_load;
	logic [15:0]         req_ext;
	logic [15:0]         add_start, add_len;
	logic [3:0]          add_rem;
	logic [12:0]         add_ceil;
	logic [15:0]         add_units;
	rba_pkg::entry_t     add_entry, bump_entry;

	assign rd_addr    = cnt_q[IDX_W-1:0];
	assign issue_done = (cnt_q == CNT_W'(REGIONS));
	assign req_ext    = {4'd0, item_q.request_size};

	// A slot never written since reset reads as empty.
	assign live_rdata = written_q[rd_idx_s1] ? rba_pkg::entry_t'(live_rdata_raw) : '0;
	assign snap_rdata = rba_pkg::entry_t'(snap_rdata_raw);

	// Add: round the start up to a unit, trim the length by the offset remainder.
	// The rounded unit count reaches 0x1000 for offsets near the top, so keep 13 bits.
	assign add_rem   = item_q.region_offset[3:0] & rba_pkg::UNIT_MASK;
	assign add_ceil  = {1'b0, item_q.region_offset[15:rba_pkg::UNIT_SHIFT]} +
	                   13'(add_rem != 4'd0);
	assign add_start = item_q.region_segment + {3'd0, add_ceil};
	assign add_len   = (item_q.region_bytes >= {12'd0, add_rem}) ?
	                   (item_q.region_bytes - {12'd0, add_rem}) : 16'd0;
	assign add_units = add_len >> rba_pkg::UNIT_SHIFT;
	assign add_entry = '{next: add_start, left: add_units};

	assign bump_entry = '{next: hit_q.next + req_ext, left: hit_q.left - req_ext};

	always_comb begin
		if (item_q.op == rba_pkg::OP_ADD) begin
			slot_hit = (live_rdata.next == 16'd0);
		end else begin
			slot_hit = (live_rdata.next != 16'd0) && (live_rdata.left >= req_ext);
		end
	end

	always_comb begin
		live_we    = 1'b0;
		live_waddr = rd_idx_s1;
		live_wdata = snap_rdata_raw;
		snap_we    = 1'b0;
		snap_waddr = rd_idx_s1;
		snap_wdata = live_rdata;
		case (state_q)
			S_RESTORE: begin
				live_we = rd_vld_s1;
			end
			S_TAKE: begin
				snap_we = rd_vld_s1;
			end
			S_SCAN: begin
				// write the new region in the cycle the empty slot is found
				live_we    = rd_vld_s1 && slot_hit && (item_q.op == rba_pkg::OP_ADD);
				live_wdata = add_entry;
			end
			S_BUMP: begin
				live_we    = 1'b1;
				live_waddr = hit_idx_q;
				live_wdata = bump_entry;
			end
			default: begin
			end
		endcase
	end

	rba_ram #(.WIDTH(ENT_W), .DEPTH(REGIONS)) u_live_ram (
		.clk   (clk),
		.we    (live_we),
		.waddr (live_waddr),
		.wdata (live_wdata),
		.raddr (rd_addr),
		.rdata (live_rdata_raw)
	);

	rba_ram #(.WIDTH(ENT_W), .DEPTH(REGIONS)) u_snap_ram (
		.clk   (clk),
		.we    (snap_we),
		.waddr (snap_waddr),
		.wdata (snap_wdata),
		.raddr (rd_addr),
		.rdata (snap_rdata_raw)
	);

	assign item.ready  = (state_q == S_IDLE);
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// load the result register once it is empty or its beat leaves this cycle
	assign out_load = (state_q == S_RESP) && (!out_vld_q || result.ready);

	// Track which live slots hold data; a restore writes every slot from a
	// checkpoint that was copied whole, so it leaves all slots marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REGIONS; k++) begin
				written_q[k] <= 1'b0;
			end
		end else if (live_we) begin
			written_q[live_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			temp_active_q <= 1'b0;
			total_free_q  <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_q     <= res_q;
			end else if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q     <= '0;
					rd_vld_s1 <= 1'b0;
					if (item.valid) begin
						item_q <= item.data;
						if (item.data.op == rba_pkg::OP_ASSIGN && !item.data.is_temp &&
						    temp_active_q) begin
							// roll back to the checkpoint first
							temp_active_q <= 1'b0;
							total_free_q  <= saved_total_q;
							state_q       <= S_RESTORE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_RESTORE, S_TAKE: begin
					if (!rd_vld_s1 && issue_done) begin
						cnt_q   <= '0;
						state_q <= (state_q == S_RESTORE) ? S_SCAN : S_BUMP;
					end else begin
						rd_vld_s1 <= !issue_done;
						rd_idx_s1 <= rd_addr;
						if (!issue_done) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_s1 && slot_hit) begin
						rd_vld_s1 <= 1'b0;
						hit_idx_q <= rd_idx_s1;
						hit_q     <= live_rdata;
						if (item_q.op == rba_pkg::OP_ADD) begin
							total_free_q <= total_free_q + add_units;
							res_q <= '{grant_segment: 16'd0,
							           total_left: total_free_q + add_units,
							           status: rba_pkg::STATUS_OK};
							state_q <= S_RESP;
						end else if (item_q.is_temp && !temp_active_q) begin
							// checkpoint before the bump lands
							temp_active_q <= 1'b1;
							saved_total_q <= total_free_q;
							cnt_q         <= '0;
							state_q       <= S_TAKE;
						end else begin
							state_q <= S_BUMP;
						end
					end else if (!rd_vld_s1 && issue_done) begin
						res_q <= '{grant_segment: 16'd0,
						           total_left: total_free_q,
						           status: (item_q.op == rba_pkg::OP_ADD) ?
						                   rba_pkg::STATUS_NO_SLOT : rba_pkg::STATUS_NO_FIT};
						state_q <= S_RESP;
					end else begin
						rd_vld_s1 <= !issue_done;
						rd_idx_s1 <= rd_addr;
						if (!issue_done) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_BUMP: begin
					total_free_q <= total_free_q - req_ext;
					res_q <= '{grant_segment: hit_q.next,
					           total_left: total_free_q - req_ext,
					           status: rba_pkg::STATUS_OK};
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
